FILE: src/video_loss_black_fill_monitor_macros.svh
// ----------------------------------------------------------------------------
// video loss monitor assertion macros
// shorthand for clocked implication checks with synchronous reset gating
// ----------------------------------------------------------------------------
`ifndef VIDEO_LOSS_BLACK_FILL_MONITOR_MACROS_SVH
`define VIDEO_LOSS_BLACK_FILL_MONITOR_MACROS_SVH

// same-cycle implication
`define VLBF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vlbf same-cycle check failed");

// next-cycle implication
`define VLBF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vlbf next-cycle check failed");

`endif

FILE: src/vlbf_pkg.sv
// ----------------------------------------------------------------------------
// vlbf_pkg
// shared types, codes and size tables for the video loss monitor
// ----------------------------------------------------------------------------
package vlbf_pkg;

   localparam int TIME_W = 48;
   localparam int DIM_W  = 12;
   localparam int LEN_W  = 25;
   localparam int ROT_W  = 16;
   localparam int MS_W   = 16;
   localparam int RES_W  = 3;

   localparam int REQ_DATA_W = 120;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 48;
   localparam int RSP_USER_W = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // commands
   localparam logic [1:0] CMD_TICK    = 2'd0;
   localparam logic [1:0] CMD_FRAME   = 2'd1;
   localparam logic [1:0] CMD_CAM_OFF = 2'd2;
   localparam logic [1:0] CMD_NONE    = 2'd3;

   // send actions
   localparam logic [1:0] ACT_NONE    = 2'd0;
   localparam logic [1:0] ACT_FORWARD = 2'd1;
   localparam logic [1:0] ACT_BLACK   = 2'd2;

   // report kinds
   localparam logic [1:0] KIND_NONE     = 2'd0;
   localparam logic [1:0] KIND_STATE    = 2'd1;
   localparam logic [1:0] KIND_MISMATCH = 2'd2;

   // stream states
   localparam logic [1:0] ST_SUBSCRIBED = 2'd0;
   localparam logic [1:0] ST_LIVE       = 2'd1;
   localparam logic [1:0] ST_BLACK      = 2'd2;

   // reasons
   localparam logic [1:0] RSN_COMMAND  = 2'd0;
   localparam logic [1:0] RSN_FRAMES   = 2'd1;
   localparam logic [1:0] RSN_CAM_OFF  = 2'd2;
   localparam logic [1:0] RSN_MISMATCH = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HOLDOFF  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NOMINAL  = 2'd2;

   localparam logic [MS_W-1:0]  HOLDOFF_RST  = 16'd200;
   localparam logic [MS_W-1:0]  INTERVAL_RST = 16'd100;
   localparam logic [RES_W-1:0] NOMINAL_RST  = 3'd3;

   typedef struct packed {
      logic [MS_W-1:0]  holdoff_ms;
      logic [MS_W-1:0]  black_interval_ms;
      logic [RES_W-1:0] nominal_resolution;
   } cfg_type;

   // captured request with the frame check already done
   typedef struct packed {
      logic [1:0]        command;
      logic [TIME_W-1:0] now_ms;
      logic              frame_ok;
      logic [DIM_W-1:0]  frame_width;
      logic [DIM_W-1:0]  frame_height;
      logic [ROT_W-1:0]  frame_rotation;
      logic              limited_range_in;
   } item_type;

   typedef struct packed {
      logic [1:0]       send_action;
      logic [DIM_W-1:0] black_width;
      logic [DIM_W-1:0] black_height;
      logic [1:0]       report_kind;
      logic [1:0]       report_state;
      logic [1:0]       report_reason;
      logic             report_measured;
      logic [ROT_W-1:0] report_rotation;
      logic             report_limited;
   } result_type;

   function automatic logic [DIM_W-1:0] nominal_width(input logic [RES_W-1:0] sel);
      logic [DIM_W-1:0] w;
      unique case (sel)
         3'd0:    w = 12'd160;
         3'd1:    w = 12'd320;
         3'd2:    w = 12'd640;
         3'd4:    w = 12'd1920;
         default: w = 12'd1280;
      endcase
      return w;
   endfunction

   function automatic logic [DIM_W-1:0] nominal_height(input logic [RES_W-1:0] sel);
      logic [DIM_W-1:0] h;
      unique case (sel)
         3'd0:    h = 12'd90;
         3'd1:    h = 12'd180;
         3'd2:    h = 12'd360;
         3'd4:    h = 12'd1080;
         default: h = 12'd720;
      endcase
      return h;
   endfunction

endpackage

FILE: src/vlbf_in_stage.sv
// ----------------------------------------------------------------------------
// vlbf_in_stage
// input register; unpacks the request beat and checks the frame geometry
// ----------------------------------------------------------------------------
module vlbf_in_stage
   import vlbf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  logic                  take,
   output logic                  item_valid,
   output item_type              item
);

   logic       valid_ff, valid_in;
   item_type   item_ff, item_in;
   logic       load;

   logic              buf_present;
   logic [DIM_W-1:0]  w, h;
   logic [LEN_W-1:0]  len;
   logic [2*DIM_W-1:0] area;
   logic [2*DIM_W+1:0] area_x3;

   assign buf_present = req_tdata[48];
   assign w           = req_tdata[60:49];
   assign h           = req_tdata[72:61];
   assign len         = req_tdata[97:73];

   // expected length is w*h*3/2
   assign area    = w * h;
   assign area_x3 = {2'b00, area} + {1'b0, area, 1'b0};

   assign req_tready = !valid_ff || take;
   assign load       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_comb begin
      item_in = item_ff;
      if (load) begin
         item_in.command          = req_tuser[1:0];
         item_in.now_ms           = req_tdata[47:0];
         item_in.frame_ok         = buf_present && (w != '0) && (h != '0)
                                    && (len == area_x3[LEN_W:1]);
         item_in.frame_width      = w;
         item_in.frame_height     = h;
         item_in.frame_rotation   = req_tdata[113:98];
         item_in.limited_range_in = req_tdata[114];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

FILE: src/vlbf_core.sv
// ----------------------------------------------------------------------------
// vlbf_core
// stream state registers and the per-item decision logic
// ----------------------------------------------------------------------------
`include "video_loss_black_fill_monitor_macros.svh"

module vlbf_core
   import vlbf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       step,
   input  item_type   item,
   output logic       res_valid,
   output result_type res
);

   logic [1:0]        state_ff, state_in;
   logic [1:0]        reason_ff, reason_in;
   logic              mm_done_ff, mm_done_in;
   logic              seen_ff, seen_in;
   logic [TIME_W-1:0] last_frame_ff, last_frame_in;
   logic [TIME_W-1:0] last_black_ff, last_black_in;
   logic [DIM_W-1:0]  last_w_ff, last_w_in;
   logic [DIM_W-1:0]  last_h_ff, last_h_in;
   logic              measured_ff, measured_in;
   logic [ROT_W-1:0]  rot_ff, rot_in;
   logic              lim_ff, lim_in;

   logic [TIME_W-1:0] since_frame, since_black;
   logic              quiet, spaced;

   // modulo 2^48 differences
   assign since_frame = item.now_ms - last_frame_ff;
   assign since_black = item.now_ms - last_black_ff;
   assign quiet  = !seen_ff || (since_frame >= {{(TIME_W-MS_W){1'b0}}, cfg.holdoff_ms});
   assign spaced = since_black >= {{(TIME_W-MS_W){1'b0}}, cfg.black_interval_ms};

   always_comb begin
      state_in      = state_ff;
      reason_in     = reason_ff;
      mm_done_in    = mm_done_ff;
      seen_in       = seen_ff;
      last_frame_in = last_frame_ff;
      last_black_in = last_black_ff;
      last_w_in     = last_w_ff;
      last_h_in     = last_h_ff;
      measured_in   = measured_ff;
      rot_in        = rot_ff;
      lim_in        = lim_ff;
      res           = '0;
      res_valid     = 1'b0;

      unique case (item.command)
         CMD_TICK: begin
            if (quiet && spaced) begin
               res_valid         = 1'b1;
               res.send_action   = ACT_BLACK;
               res.black_width   = (last_w_ff != '0) ? last_w_ff
                                   : nominal_width(cfg.nominal_resolution);
               res.black_height  = (last_h_ff != '0) ? last_h_ff
                                   : nominal_height(cfg.nominal_resolution);
               last_black_in     = item.now_ms;
               if (seen_ff && state_ff != ST_BLACK) begin
                  state_in          = ST_BLACK;
                  reason_in         = (reason_ff == RSN_MISMATCH) ? RSN_MISMATCH
                                                                  : RSN_CAM_OFF;
                  res.report_kind   = KIND_STATE;
                  res.report_state  = ST_BLACK;
                  res.report_reason = reason_in;
               end
            end
         end
         CMD_FRAME: begin
            if (!item.frame_ok) begin
               if (!mm_done_ff) begin
                  res_valid         = 1'b1;
                  mm_done_in        = 1'b1;
                  reason_in         = RSN_MISMATCH;
                  res.report_kind   = KIND_MISMATCH;
                  res.report_reason = RSN_MISMATCH;
               end
            end else begin
               res_valid     = 1'b1;
               res.send_action = ACT_FORWARD;
               last_frame_in = item.now_ms;
               seen_in       = 1'b1;
               last_w_in     = item.frame_width;
               last_h_in     = item.frame_height;
               if (!measured_ff || state_ff != ST_LIVE ||
                   rot_ff != item.frame_rotation || lim_ff != item.limited_range_in) begin
                  measured_in         = 1'b1;
                  rot_in              = item.frame_rotation;
                  lim_in              = item.limited_range_in;
                  state_in            = ST_LIVE;
                  reason_in           = RSN_FRAMES;
                  res.report_kind     = KIND_STATE;
                  res.report_state    = ST_LIVE;
                  res.report_reason   = RSN_FRAMES;
                  res.report_measured = 1'b1;
                  res.report_rotation = item.frame_rotation;
                  res.report_limited  = item.limited_range_in;
               end
            end
         end
         CMD_CAM_OFF: begin
            res_valid         = 1'b1;
            state_in          = ST_BLACK;
            reason_in         = RSN_CAM_OFF;
            res.report_kind   = KIND_STATE;
            res.report_state  = ST_BLACK;
            res.report_reason = RSN_CAM_OFF;
         end
         CMD_NONE: begin
            res_valid = 1'b0;
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SUBSCRIBED;
         reason_ff     <= RSN_COMMAND;
         mm_done_ff    <= 1'b0;
         seen_ff       <= 1'b0;
         last_frame_ff <= '0;
         last_black_ff <= '0;
         last_w_ff     <= '0;
         last_h_ff     <= '0;
         measured_ff   <= 1'b0;
         rot_ff        <= '0;
         lim_ff        <= 1'b1;
      end else if (step) begin
         state_ff      <= state_in;
         reason_ff     <= reason_in;
         mm_done_ff    <= mm_done_in;
         seen_ff       <= seen_in;
         last_frame_ff <= last_frame_in;
         last_black_ff <= last_black_in;
         last_w_ff     <= last_w_in;
         last_h_ff     <= last_h_in;
         measured_ff   <= measured_in;
         rot_ff        <= rot_in;
         lim_ff        <= lim_in;
      end
   end

   // a result always carries either a send or a report
   `VLBF_ASSERT_IMPL(a_res_not_empty, clock, reset, step && res_valid, (res.send_action != ACT_NONE) || (res.report_kind != KIND_NONE))
   // the mismatch error goes out only once after reset
   `VLBF_ASSERT_IMPL(a_mm_once, clock, reset, step && res_valid && (res.report_kind == KIND_MISMATCH), !mm_done_ff)
   // a black frame never has a zero size
   `VLBF_ASSERT_IMPL(a_black_size, clock, reset, res.send_action == ACT_BLACK, (res.black_width != '0) && (res.black_height != '0))
   // a forwarded frame leaves the stream live
   `VLBF_ASSERT_NEXT(a_fwd_live, clock, reset, step && res_valid && (res.send_action == ACT_FORWARD), (state_ff == ST_LIVE) && seen_ff)

endmodule

FILE: src/vlbf_out_stage.sv
// ----------------------------------------------------------------------------
// vlbf_out_stage
// result register driving the response stream
// ----------------------------------------------------------------------------
module vlbf_out_stage
   import vlbf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  result_type            res,
   output logic                  free,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [RSP_USER_W-1:0] rsp_tuser
);

   logic       valid_ff, valid_in;
   result_type res_ff, res_in;

   assign free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      if (load) begin
         valid_in = 1'b1;
         res_in   = res;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = {res_ff.report_kind, res_ff.send_action};
   assign rsp_tdata  = {2'b00,
                        res_ff.report_limited,
                        res_ff.report_rotation,
                        res_ff.report_measured,
                        res_ff.report_reason,
                        res_ff.report_state,
                        res_ff.black_height,
                        res_ff.black_width};

endmodule

FILE: src/video_loss_black_fill_monitor.sv
// ----------------------------------------------------------------------------
// video_loss_black_fill_monitor
// per-stream video watchdog: checks frames, tracks live/black state and
// emits rate-limited black frames after a silence
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake              carries
//  req_     in         req_tvalid/req_tready  tick, frame or camera-off beat
//  rsp_     out        rsp_tvalid/rsp_tready  send action plus state report
//  csr_     in         csr_we                 holdoff, black interval, nominal size
//
//  one beat per cycle sustained while rsp_ does not stall; each result goes
//  through the input register, then the result register, to rsp_
//  the width*height product is formed at capture; the decision and state
//  update are combinational between the input and result registers
//  reset is synchronous: stream state cleared, registers back to 200 ms,
//  100 ms and 720p
//  a stalled rsp_ holds its result while one more request waits in the
//  input register, so req_tready drops only when both are occupied
//  beats that produce no result (ticks inside the holdoff or black interval,
//  repeated bad frames, command 3) are consumed without a response beat
//
module video_loss_black_fill_monitor
   import vlbf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // now_ms[47:0] buffer_present[48] frame_width[60:49] frame_height[72:61]
   // buffer_length[97:73] frame_rotation[113:98] limited_range_in[114] pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // command[1:0]
   input  logic [REQ_USER_W-1:0] req_tuser,
   // response stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // black_width[11:0] black_height[23:12] report_state[25:24]
   // report_reason[27:26] report_measured[28] report_rotation[44:29]
   // report_limited[45] pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // send_action[1:0] report_kind[3:2]
   output logic [RSP_USER_W-1:0] rsp_tuser,
   // register writes
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg_ff, cfg_in;
   logic       item_valid;
   item_type   item;
   logic       out_free;
   logic       step;
   logic       res_valid;
   result_type res;

   // control registers; index 3 is ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_HOLDOFF:  cfg_in.holdoff_ms         = csr_wdata;
            CSR_INTERVAL: cfg_in.black_interval_ms  = csr_wdata;
            CSR_NOMINAL:  cfg_in.nominal_resolution = csr_wdata[RES_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.holdoff_ms         <= HOLDOFF_RST;
         cfg_ff.black_interval_ms  <= INTERVAL_RST;
         cfg_ff.nominal_resolution <= NOMINAL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // the captured item is processed once the result register can take it
   assign step = item_valid && out_free;

   vlbf_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .take       (step),
      .item_valid (item_valid),
      .item       (item)
   );

   vlbf_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .step      (step),
      .item      (item),
      .res_valid (res_valid),
      .res       (res)
   );

   vlbf_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (step && res_valid),
      .res        (res),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
